[rtl/core/rdsg_pkg.sv]
// ----------------------------------------------------------------------------
// rdsg_pkg
// Shared types, codes and helpers for the RDS group decoder.
// ----------------------------------------------------------------------------
package rdsg_pkg;

   // item operation codes
   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // group type codes
   localparam logic [3:0] GROUP_PS = 4'd0;
   localparam logic [3:0] GROUP_RT = 4'd2;

   // read index map
   localparam logic [6:0] TEXT_BASE = 7'd16;
   localparam logic [6:0] TEXT_END  = 7'd80;

   // characters
   localparam logic [7:0] ASCII_ZERO   = 8'd48;
   localparam logic [7:0] ASCII_ALPHA  = 8'd55;
   localparam logic [3:0] DIGIT_MAX    = 4'd9;
   localparam logic [7:0] ASCII_SPACE  = 8'h20;

   // name pair write request
   typedef struct packed {
      logic        write;
      logic [15:0] pair;
   } name_cmd_type;

   // radio text group request
   typedef struct packed {
      logic        write;
      logic        read;
      logic        ver_b;
      logic        flag;
      logic [3:0]  seg;
      logic        ok_c;
      logic        ok_d;
      logic [15:0] data_c;
      logic [15:0] data_d;
   } text_cmd_type;

   // one nibble to its ASCII hex digit
   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      return (nib > DIGIT_MAX) ? wide + ASCII_ALPHA : wide + ASCII_ZERO;
   endfunction

endpackage

[rtl/core/rdsg_name.sv]
// ----------------------------------------------------------------------------
// rdsg_name
// Two program service name lines with seen/confirm tracking and line switch.
// ----------------------------------------------------------------------------
module rdsg_name (
   input  logic                  clock,
   input  logic                  reset,
   input  rdsg_pkg::name_cmd_type cmd,
   input  logic [1:0]            addr,
   input  logic                  rd_line,
   input  logic                  rd_low,
   output logic [7:0]            rd_char,
   output logic                  line_next
);

   logic [15:0] line0_ff [4];
   logic [15:0] line0_in [4];
   logic [15:0] line1_ff [4];
   logic [15:0] line1_in [4];
   logic [3:0]  seen_ff  [2];
   logic [3:0]  seen_in  [2];
   logic [3:0]  conf_ff  [2];
   logic [3:0]  conf_in  [2];
   logic        line_ff;
   logic        line_in;

   logic [15:0] pair0, pair1, pair_cur, pair_oth, pair_new, rd_pair;
   logic [3:0]  bit_sel;
   logic        cur, oth, switch_line, ncur;

   // one read port per line, shared by decode and read items
   assign pair0    = line0_ff[addr];
   assign pair1    = line1_ff[addr];
   assign rd_pair  = rd_line ? pair1 : pair0;
   assign rd_char  = rd_low ? rd_pair[7:0] : rd_pair[15:8];

   assign bit_sel  = 4'd1 << addr;
   assign cur      = line_ff;
   assign oth      = ~line_ff;
   assign pair_cur = cur ? pair1 : pair0;
   assign pair_oth = cur ? pair0 : pair1;

   // a confirmed pair that changes moves display to the other line
   assign switch_line = ((conf_ff[cur] & bit_sel) != 4'd0) && (pair_cur != cmd.pair) &&
                        (((conf_ff[oth] & bit_sel) == 4'd0) || (pair_oth == cmd.pair));
   assign ncur      = switch_line ? oth : cur;
   assign pair_new  = switch_line ? pair_oth : pair_cur;
   assign line_next = cmd.write ? ncur : line_ff;

   // next state
   always_comb begin
      line0_in = line0_ff;
      line1_in = line1_ff;
      seen_in  = seen_ff;
      conf_in  = conf_ff;
      line_in  = line_ff;
      if (cmd.write) begin
         line_in = ncur;
         if (((seen_ff[ncur] & bit_sel) != 4'd0) && (pair_new == cmd.pair)) begin
            conf_in[ncur] = conf_ff[ncur] | bit_sel;
         end else begin
            seen_in[ncur] = seen_ff[ncur] | bit_sel;
         end
         if (ncur) begin
            line1_in[addr] = cmd.pair;
         end else begin
            line0_in[addr] = cmd.pair;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            line0_ff[i] <= '0;
            line1_ff[i] <= '0;
         end
         seen_ff[0] <= '0;
         seen_ff[1] <= '0;
         conf_ff[0] <= '0;
         conf_ff[1] <= '0;
         line_ff    <= 1'b0;
      end else begin
         line0_ff <= line0_in;
         line1_ff <= line1_in;
         seen_ff  <= seen_in;
         conf_ff  <= conf_in;
         line_ff  <= line_in;
      end
   end

endmodule

[rtl/core/rdsg_text.sv]
// ----------------------------------------------------------------------------
// rdsg_text
// Radio text store: 32 character pairs in even/odd banks, written mask,
// A/B flag and clear-to-space handling.
// ----------------------------------------------------------------------------
module rdsg_text (
   input  logic                  clock,
   input  logic                  reset,
   input  rdsg_pkg::text_cmd_type cmd,
   input  logic [5:0]            rd_pos,
   output logic [7:0]            rd_char,
   output logic                  changed
);

   // pair banks carry no reset; the written mask qualifies every entry
   logic [15:0] even_ff [16];
   logic [15:0] even_in [16];
   logic [15:0] odd_ff  [16];
   logic [15:0] odd_in  [16];
   logic [31:0] mask_ff;
   logic [31:0] mask_in;
   logic        fill_ff;      // text has been cleared to spaces at least once
   logic        fill_in;
   logic        ab_ff;
   logic        ab_in;

   logic [3:0]  addr;
   logic [15:0] rd_even, rd_odd, rd_pair;
   logic [4:0]  bit_c, bit_d;
   logic [15:0] old_c, old_d;
   logic        wr_c, wr_d, toggle, clr_c, clr_d, any_clr;
   logic        wr_even, wr_odd;
   logic [15:0] even_data;
   logic [7:0]  fill_char;

   // one address per bank for either a read or a decode
   always_comb begin
      if (cmd.read) begin
         addr = rd_pos[5:2];
      end else if (cmd.ver_b) begin
         addr = {1'b0, cmd.seg[3:1]};
      end else begin
         addr = cmd.seg;
      end
   end

   assign rd_even = even_ff[addr];
   assign rd_odd  = odd_ff[addr];

   // read side: an unwritten pair shows the fill character
   assign rd_pair   = rd_pos[1] ? rd_odd : rd_even;
   assign fill_char = fill_ff ? rdsg_pkg::ASCII_SPACE : 8'd0;
   assign rd_char   = mask_ff[rd_pos[5:1]] ? (rd_pos[0] ? rd_pair[7:0] : rd_pair[15:8])
                                           : fill_char;

   // pair selection: version A uses C (even) and D (odd), version B only D
   assign wr_c  = cmd.write && !cmd.ver_b && cmd.ok_c;
   assign wr_d  = cmd.write && cmd.ok_d;
   assign bit_c = {cmd.seg, 1'b0};
   assign bit_d = cmd.ver_b ? {1'b0, cmd.seg} : {cmd.seg, 1'b1};
   assign old_c = rd_even;
   assign old_d = (cmd.ver_b && !cmd.seg[0]) ? rd_even : rd_odd;

   // clear checks in group order: flag toggle, then C, then D
   assign toggle  = cmd.write && (cmd.flag != ab_ff);
   assign clr_c   = wr_c && mask_ff[bit_c] && !toggle && (old_c != cmd.data_c);
   assign clr_d   = wr_d && mask_ff[bit_d] && !toggle && !clr_c && (old_d != cmd.data_d);
   assign any_clr = toggle || clr_c || clr_d;
   assign changed = toggle || wr_c || wr_d;

   assign wr_even   = wr_c || (wr_d && cmd.ver_b && !cmd.seg[0]);
   assign wr_odd    = wr_d && (!cmd.ver_b || cmd.seg[0]);
   assign even_data = cmd.ver_b ? cmd.data_d : cmd.data_c;

   // next state
   always_comb begin
      even_in = even_ff;
      odd_in  = odd_ff;
      mask_in = any_clr ? 32'd0 : mask_ff;
      if (wr_c && !clr_d) begin
         mask_in = mask_in | (32'd1 << bit_c);
      end
      if (wr_d) begin
         mask_in = mask_in | (32'd1 << bit_d);
      end
      if (wr_even) begin
         even_in[addr] = even_data;
      end
      if (wr_odd) begin
         odd_in[addr] = cmd.data_d;
      end
      fill_in = fill_ff || any_clr;
      ab_in   = cmd.write ? cmd.flag : ab_ff;
   end

   always_ff @(posedge clock) begin
      even_ff <= even_in;
      odd_ff  <= odd_in;
      if (reset) begin
         mask_ff <= '0;
         fill_ff <= 1'b0;
         ab_ff   <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         fill_ff <= fill_in;
         ab_ff   <= ab_in;
      end
   end

endmodule

[rtl/core/rds_group_decoder.sv]
// Decodes one RDS group or reads one stored character per beat. A beat is
// taken into an input register, processed there against the name, text
// and PI state, and its result lands in an output register, so one beat
// per clock is sustained while the result side keeps up; a stall on the
// result side holds the input register and then stalls the request side.
// Groups with a bad block B change nothing. Character reads use index
// 0-15 for the two name lines, 16-79 for radio text, and return 0 beyond
// that.
// ----------------------------------------------------------------------------
// rds_group_decoder
// RDS program service name and radio text decoder, top level.
// ----------------------------------------------------------------------------
module rds_group_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_block_a,
   input  logic [15:0] req_block_b,
   input  logic [15:0] req_block_c,
   input  logic [15:0] req_block_d,
   input  logic        req_ok_a,
   input  logic        req_ok_b,
   input  logic        req_ok_c,
   input  logic        req_ok_d,
   input  logic [6:0]  req_read_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_char,
   output logic [31:0] rsp_pi_ascii,
   output logic        rsp_active_line,
   output logic        rsp_name_changed,
   output logic        rsp_text_changed
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        op_ff;
   logic [15:0] a_ff, b_ff, c_ff, d_ff;
   logic        oka_ff, okb_ff, okc_ff, okd_ff;
   logic [6:0]  idx_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  char_ff, char_in;
   logic [31:0] pi_out_ff;
   logic        line_out_ff;
   logic        nchg_ff, nchg_in;
   logic        tchg_ff, tchg_in;

   // PI state
   logic [31:0] pi_ff, pi_in;

   logic        accept, advance;
   logic        decode, is_read;
   logic [3:0]  group_type;
   logic [6:0]  text_off;
   logic [7:0]  name_char, text_char;
   logic        line_next, text_chg;

   rdsg_pkg::name_cmd_type name_cmd;
   rdsg_pkg::text_cmd_type text_cmd;

   // handshake: the held beat moves on when the result slot frees up
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // group decode
   assign is_read    = (op_ff == rdsg_pkg::OP_READ);
   assign decode     = advance && !is_read && okb_ff;
   assign group_type = b_ff[15:12];
   assign text_off   = idx_ff - rdsg_pkg::TEXT_BASE;

   assign pi_in = (decode && oka_ff) ?
                  {rdsg_pkg::hex_ascii(a_ff[15:12]), rdsg_pkg::hex_ascii(a_ff[11:8]),
                   rdsg_pkg::hex_ascii(a_ff[7:4]), rdsg_pkg::hex_ascii(a_ff[3:0])} : pi_ff;

   assign name_cmd.write = decode && (group_type == rdsg_pkg::GROUP_PS) && okd_ff;
   assign name_cmd.pair  = d_ff;

   assign text_cmd.write  = decode && (group_type == rdsg_pkg::GROUP_RT);
   assign text_cmd.read   = is_read;
   assign text_cmd.ver_b  = b_ff[11];
   assign text_cmd.flag   = b_ff[4];
   assign text_cmd.seg    = b_ff[3:0];
   assign text_cmd.ok_c   = okc_ff;
   assign text_cmd.ok_d   = okd_ff;
   assign text_cmd.data_c = c_ff;
   assign text_cmd.data_d = d_ff;

   rdsg_name u_name (
      .clock     (clock),
      .reset     (reset),
      .cmd       (name_cmd),
      .addr      (is_read ? idx_ff[2:1] : b_ff[1:0]),
      .rd_line   (idx_ff[3]),
      .rd_low    (idx_ff[0]),
      .rd_char   (name_char),
      .line_next (line_next)
   );

   rdsg_text u_text (
      .clock   (clock),
      .reset   (reset),
      .cmd     (text_cmd),
      .rd_pos  (text_off[5:0]),
      .rd_char (text_char),
      .changed (text_chg)
   );

   // result fields
   always_comb begin
      char_in = 8'd0;
      if (is_read) begin
         if (idx_ff < rdsg_pkg::TEXT_BASE) begin
            char_in = name_char;
         end else if (idx_ff < rdsg_pkg::TEXT_END) begin
            char_in = text_char;
         end
      end
      nchg_in = name_cmd.write;
      tchg_in = text_cmd.write && text_chg;
   end

   // request beat capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         op_ff  <= req_operation;
         a_ff   <= req_block_a;
         b_ff   <= req_block_b;
         c_ff   <= req_block_c;
         d_ff   <= req_block_d;
         oka_ff <= req_ok_a;
         okb_ff <= req_ok_b;
         okc_ff <= req_ok_c;
         okd_ff <= req_ok_d;
         idx_ff <= req_read_index;
      end
   end

   // PI state and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pi_ff        <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         pi_ff        <= pi_in;
      end
      if (advance) begin
         char_ff     <= char_in;
         pi_out_ff   <= pi_in;
         line_out_ff <= line_next;
         nchg_ff     <= nchg_in;
         tchg_ff     <= tchg_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_char    = char_ff;
   assign rsp_pi_ascii     = pi_out_ff;
   assign rsp_active_line  = line_out_ff;
   assign rsp_name_changed = nchg_ff;
   assign rsp_text_changed = tchg_ff;

endmodule
